/* design/uart_line_receiver_unit_defines.svh */
// Assertion macros used by the UART line receiver top level.
`ifndef UART_LINE_RECEIVER_UNIT_DEFINES_SVH
`define UART_LINE_RECEIVER_UNIT_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ULR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a trigger in one cycle implies a consequence in the same cycle.
`define ULR_ASSERT_IMPLY(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// Checks that a trigger in one cycle implies a consequence in the next cycle.
`define ULR_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

/* design/ulr_pkg.sv */
// Types and constants shared by the UART line receiver modules.
package ulr_pkg;

    localparam logic [1:0] KIND_STORED    = 2'd0;
    localparam logic [1:0] KIND_READ      = 2'd1;
    localparam logic [1:0] KIND_FRAME_ERR = 2'd2;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [1:0] CFG_HALF_BIT = 2'd0;
    localparam logic [1:0] CFG_FULL_BIT = 2'd1;
    localparam logic [1:0] CFG_END_BYTE = 2'd2;

    localparam logic [15:0] HALF_BIT_RESET = 16'd3333;
    localparam logic [15:0] FULL_BIT_RESET = 16'd6666;
    localparam logic [7:0]  END_BYTE_RESET = 8'h0A;

    typedef enum logic [2:0] {
        PH_ARMED    = 3'd0,
        PH_DISARMED = 3'd1,
        PH_START    = 3'd2,
        PH_BITS     = 3'd3,
        PH_STOP1    = 3'd4,
        PH_STOP2    = 3'd5
    } rx_phase_t;

    typedef enum logic [1:0] {
        RO_IDLE  = 2'd0,
        RO_FETCH = 2'd1,
        RO_EMIT  = 2'd2
    } ro_state_t;

    typedef struct packed {
        logic req_type;
        logic rx_line;
    } req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
        logic       message_ready;
    } rsp_t;

    typedef struct packed {
        logic [15:0] half_bit_ticks;
        logic [15:0] full_bit_ticks;
        logic [7:0]  message_end_byte;
    } cfg_t;

    typedef struct packed {
        logic       err;
        logic       store;
        logic       end_hit;
        logic [7:0] data;
    } rx_event_t;

    typedef struct packed {
        logic busy;
        logic empty;
        logic ready;
    } store_status_t;

endpackage

/* design/uart_line_receiver_unit.sv */
// Top level of the UART line receiver: configuration, request handling and result register.
// Each tick transaction carries one sample of the receive line, so ticks flow at one per cycle
// as long as results are taken and no read-out is running; a tick that yields a byte or a
// framing error places one result in the output register. A read transaction stalls the
// request channel while the sequencer walks the message memory through its single registered
// read port, fetching and then emitting each stored byte; an empty store yields one result.
// The message memory needs no clearing pass after reset: only entries below the fill count
// are ever read out.
`include "uart_line_receiver_unit_defines.svh"

module uart_line_receiver_unit #(
    parameter int STORE_DEPTH = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  ulr_pkg::req_t   req_data,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output ulr_pkg::rsp_t   rsp_data,
    input  logic            cfg_write,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data
);

    ulr_pkg::cfg_t          cfg_reg, cfg_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    ulr_pkg::rsp_t          rsp_data_reg, rsp_data_next;

    logic                   slot_free;
    logic                   accept;
    logic                   tick;
    logic                   rd;
    ulr_pkg::rx_event_t     ev;
    logic                   ro_valid;
    ulr_pkg::rsp_t          ro_result;
    ulr_pkg::store_status_t status;

    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !slot_free || status.busy;
    assign accept    = req_valid && !req_stall;
    assign tick      = accept && (req_data.req_type == ulr_pkg::REQ_TICK);
    assign rd        = accept && (req_data.req_type == ulr_pkg::REQ_READ);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    ulr_sampler u_sampler (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (tick),
        .line  (req_data.rx_line),
        .rearm (rd),
        .cfg   (cfg_reg),
        .ev    (ev)
    );

    ulr_store #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev        (ev),
        .rd_start  (rd),
        .slot_free (slot_free),
        .ro_valid  (ro_valid),
        .ro_result (ro_result),
        .status    (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_bit_ticks   <= ulr_pkg::HALF_BIT_RESET;
            cfg_reg.full_bit_ticks   <= ulr_pkg::FULL_BIT_RESET;
            cfg_reg.message_end_byte <= ulr_pkg::END_BYTE_RESET;
            rsp_valid_reg            <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                ulr_pkg::CFG_HALF_BIT: cfg_next.half_bit_ticks   = cfg_data;
                ulr_pkg::CFG_FULL_BIT: cfg_next.full_bit_ticks   = cfg_data;
                ulr_pkg::CFG_END_BYTE: cfg_next.message_end_byte = cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_data_next  = rsp_data_reg;
        if (slot_free)
        begin
            if (ro_valid)
            begin
                rsp_valid_next = 1'b1;
                rsp_data_next  = ro_result;
            end
            else if (ev.err)
            begin
                rsp_valid_next              = 1'b1;
                rsp_data_next.kind          = ulr_pkg::KIND_FRAME_ERR;
                rsp_data_next.data_byte     = 8'd0;
                rsp_data_next.byte_valid    = 1'b0;
                rsp_data_next.last          = 1'b0;
                rsp_data_next.message_ready = status.ready;
            end
            else if (ev.store)
            begin
                rsp_valid_next              = 1'b1;
                rsp_data_next.kind          = ulr_pkg::KIND_STORED;
                rsp_data_next.data_byte     = ev.data;
                rsp_data_next.byte_valid    = 1'b1;
                rsp_data_next.last          = 1'b0;
                rsp_data_next.message_ready = status.ready || ev.end_hit;
            end
            else if (rd && status.empty)
            begin
                rsp_valid_next              = 1'b1;
                rsp_data_next.kind          = ulr_pkg::KIND_READ;
                rsp_data_next.data_byte     = 8'd0;
                rsp_data_next.byte_valid    = 1'b0;
                rsp_data_next.last          = 1'b1;
                rsp_data_next.message_ready = 1'b0;
            end
        end
    end

    `ULR_ASSERT_ALWAYS(a_event_exclusive, !(ev.err && ev.store), "sampler raised error and store together")
    `ULR_ASSERT_IMPLY(a_readout_alone, ro_valid, !ev.err && !ev.store, "read-out collided with a received result")
    `ULR_ASSERT_NEXT(a_read_clears_ready, rd, !status.ready && status.empty, "read did not clear the message")
    `ULR_ASSERT_IMPLY(a_empty_read_last, rsp_valid_reg && !rsp_data_reg.byte_valid && (rsp_data_reg.kind == ulr_pkg::KIND_READ), rsp_data_reg.last, "empty read result without last")

endmodule

/* design/ulr_sampler.sv */
// Receive line sampler: start detection, bit timing and serial data shift register.
module ulr_sampler (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 line,
    input  logic                 rearm,
    input  ulr_pkg::cfg_t        cfg,
    output ulr_pkg::rx_event_t   ev
);

    ulr_pkg::rx_phase_t phase_reg, phase_next;
    logic [15:0] tick_cnt_reg, tick_cnt_next;
    logic [3:0]  bit_cnt_reg, bit_cnt_next;
    logic [7:0]  shift_reg, shift_next;
    logic        prev_line_reg, prev_line_next;

    logic [15:0] cnt_inc;
    logic [15:0] target;
    logic        hit;
    logic [3:0]  bit_inc;
    logic        edge_seen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ulr_pkg::PH_ARMED;
            tick_cnt_reg  <= 16'd0;
            bit_cnt_reg   <= 4'd0;
            shift_reg     <= 8'd0;
            prev_line_reg <= 1'b1;
        end
        else
        begin
            phase_reg     <= phase_next;
            tick_cnt_reg  <= tick_cnt_next;
            bit_cnt_reg   <= bit_cnt_next;
            shift_reg     <= shift_next;
            prev_line_reg <= prev_line_next;
        end
    end

    always_comb
    begin
        cnt_inc   = tick_cnt_reg + 16'd1;
        target    = (phase_reg == ulr_pkg::PH_START) ? cfg.half_bit_ticks
                                                     : cfg.full_bit_ticks;
        hit       = (cnt_inc >= target);
        bit_inc   = bit_cnt_reg + 4'd1;
        edge_seen = prev_line_reg && !line;

        phase_next     = phase_reg;
        tick_cnt_next  = tick_cnt_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        prev_line_next = prev_line_reg;
        ev             = '0;
        ev.data        = shift_reg;

        if (rearm && (phase_reg == ulr_pkg::PH_DISARMED))
        begin
            phase_next = ulr_pkg::PH_ARMED;
        end

        if (step)
        begin
            prev_line_next = line;
            case (phase_reg)
                ulr_pkg::PH_ARMED:
                begin
                    if (edge_seen)
                    begin
                        tick_cnt_next = 16'd0;
                        phase_next    = ulr_pkg::PH_START;
                    end
                end
                ulr_pkg::PH_DISARMED:
                begin
                end
                ulr_pkg::PH_START:
                begin
                    tick_cnt_next = hit ? 16'd0 : cnt_inc;
                    if (hit)
                    begin
                        if (line)
                        begin
                            phase_next = ulr_pkg::PH_ARMED;
                            ev.err     = 1'b1;
                        end
                        else
                        begin
                            phase_next   = ulr_pkg::PH_BITS;
                            bit_cnt_next = 4'd0;
                            shift_next   = 8'd0;
                        end
                    end
                end
                ulr_pkg::PH_BITS:
                begin
                    tick_cnt_next = hit ? 16'd0 : cnt_inc;
                    if (hit)
                    begin
                        shift_next   = {line, shift_reg[7:1]};
                        bit_cnt_next = bit_inc;
                        if (bit_inc[3])
                        begin
                            phase_next = ulr_pkg::PH_STOP1;
                        end
                    end
                end
                ulr_pkg::PH_STOP1:
                begin
                    tick_cnt_next = hit ? 16'd0 : cnt_inc;
                    if (hit)
                    begin
                        if (!line)
                        begin
                            phase_next = ulr_pkg::PH_ARMED;
                            ev.err     = 1'b1;
                        end
                        else
                        begin
                            phase_next = ulr_pkg::PH_STOP2;
                        end
                    end
                end
                ulr_pkg::PH_STOP2:
                begin
                    tick_cnt_next = hit ? 16'd0 : cnt_inc;
                    if (hit)
                    begin
                        phase_next = ulr_pkg::PH_ARMED;
                        if (line)
                        begin
                            ev.store = 1'b1;
                            if (shift_reg == cfg.message_end_byte)
                            begin
                                ev.end_hit = 1'b1;
                                phase_next = ulr_pkg::PH_DISARMED;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = ulr_pkg::PH_ARMED;
                    if (edge_seen)
                    begin
                        tick_cnt_next = 16'd0;
                        phase_next    = ulr_pkg::PH_START;
                    end
                end
            endcase
        end
    end

endmodule

/* design/ulr_store.sv */
// Message store: byte memory, fill count, ready flag and read-out sequencer.
module ulr_store #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ulr_pkg::rx_event_t       ev,
    input  logic                     rd_start,
    input  logic                     slot_free,
    output logic                     ro_valid,
    output ulr_pkg::rsp_t            ro_result,
    output ulr_pkg::store_status_t   status
);

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_DEPTH - 1);

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;

    logic [IDX_W-1:0] count_reg, count_next;
    logic             ready_reg, ready_next;
    logic [IDX_W-1:0] ro_idx_reg, ro_idx_next;
    logic [IDX_W-1:0] ro_end_reg, ro_end_next;
    ulr_pkg::ro_state_t ro_state_reg, ro_state_next;

    always_ff @(posedge clk)
    begin
        if (ev.store)
        begin
            mem[count_reg] <= ev.data;
        end
        if (ro_state_reg == ulr_pkg::RO_FETCH)
        begin
            rd_data_reg <= mem[ro_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ready_reg    <= 1'b0;
            ro_idx_reg   <= '0;
            ro_end_reg   <= '0;
            ro_state_reg <= ulr_pkg::RO_IDLE;
        end
        else
        begin
            count_reg    <= count_next;
            ready_reg    <= ready_next;
            ro_idx_reg   <= ro_idx_next;
            ro_end_reg   <= ro_end_next;
            ro_state_reg <= ro_state_next;
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        ready_next    = ready_reg;
        ro_idx_next   = ro_idx_reg;
        ro_end_next   = ro_end_reg;
        ro_state_next = ro_state_reg;

        ro_valid                = 1'b0;
        ro_result.kind          = ulr_pkg::KIND_READ;
        ro_result.data_byte     = rd_data_reg;
        ro_result.byte_valid    = 1'b1;
        ro_result.last          = (ro_idx_reg == ro_end_reg);
        ro_result.message_ready = 1'b0;

        if (ev.store)
        begin
            if (count_reg != LAST_IDX)
            begin
                count_next = count_reg + IDX_W'(1);
            end
            if (ev.end_hit)
            begin
                ready_next = 1'b1;
            end
        end

        if (rd_start)
        begin
            count_next  = '0;
            ready_next  = 1'b0;
            ro_idx_next = '0;
            ro_end_next = count_reg - IDX_W'(1);
            if (count_reg != '0)
            begin
                ro_state_next = ulr_pkg::RO_FETCH;
            end
        end

        case (ro_state_reg)
            ulr_pkg::RO_IDLE:
            begin
            end
            ulr_pkg::RO_FETCH:
            begin
                ro_state_next = ulr_pkg::RO_EMIT;
            end
            ulr_pkg::RO_EMIT:
            begin
                if (slot_free)
                begin
                    ro_valid = 1'b1;
                    if (ro_idx_reg == ro_end_reg)
                    begin
                        ro_state_next = ulr_pkg::RO_IDLE;
                    end
                    else
                    begin
                        ro_idx_next   = ro_idx_reg + IDX_W'(1);
                        ro_state_next = ulr_pkg::RO_FETCH;
                    end
                end
            end
            default:
            begin
                ro_state_next = ulr_pkg::RO_IDLE;
            end
        endcase

        status.busy  = (ro_state_reg != ulr_pkg::RO_IDLE);
        status.empty = (count_reg == '0);
        status.ready = ready_reg;
    end

endmodule
